>>> rtl/core/bmhq_pkg.sv
// Package for the binary min-heap queue: payload beat types, command and
// status codes, key limits and the sequencer state type.
// No dependencies.
package bmhq_pkg;

    localparam int KEY_W   = 32;
    localparam int IDX_W   = 10;
    localparam int CNT_W   = 11;
    localparam int CFG_W   = 11;
    localparam int STAT_W  = 3;

    localparam logic [CFG_W-1:0] CAP_RESET = 11'd1024;

    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

    localparam logic [1:0] CMD_INSERT   = 2'd0;
    localparam logic [1:0] CMD_EXTRACT  = 2'd1;
    localparam logic [1:0] CMD_DECREASE = 2'd2;
    localparam logic [1:0] CMD_DELETE   = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY      = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL       = 3'd2;
    localparam logic [STAT_W-1:0] ST_RANGE      = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOTSMALLER = 3'd4;

    typedef struct packed {
        logic [1:0]              cmd;
        logic signed [KEY_W-1:0] key;
        logic [IDX_W-1:0]        index;
    } t_cmd_beat;

    typedef struct packed {
        logic signed [KEY_W-1:0] value;
        logic [STAT_W-1:0]       status;
        logic [CNT_W-1:0]        count;
    } t_result_beat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_DEC_CMP,
        S_RISE_CHK,
        S_RISE_CMP,
        S_TAKE_R0,
        S_TAKE_RL,
        S_TAKE_LD,
        S_SINK_CHK,
        S_SINK_RL,
        S_SINK_RR
    } t_state;

endpackage

>>> rtl/core/bmhq_mem.sv
// Heap key storage: one write port and one registered read port.
// Depends on bmhq_pkg for the key width.
module bmhq_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                               i_clk,
    input  logic                               i_we,
    input  logic [AW-1:0]                      i_waddr,
    input  logic signed [bmhq_pkg::KEY_W-1:0]  i_wdata,
    input  logic [AW-1:0]                      i_raddr,
    output logic signed [bmhq_pkg::KEY_W-1:0]  o_rdata
);

    logic signed [bmhq_pkg::KEY_W-1:0] r_mem [DEPTH];
    logic signed [bmhq_pkg::KEY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/bmhq_ctrl.sv
// Heap sequencer: command dispatch, sift-up and sift-down over the key
// memory with one shared signed comparator. Depends on bmhq_pkg.
module bmhq_ctrl #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int CW    = 11
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  bmhq_pkg::t_cmd_beat                i_cmd,
    input  logic [bmhq_pkg::CFG_W-1:0]         i_cap,
    output logic                               o_busy,
    output logic                               o_done,
    output bmhq_pkg::t_result_beat             o_result,
    output logic                               o_mem_we,
    output logic [AW-1:0]                      o_mem_waddr,
    output logic signed [bmhq_pkg::KEY_W-1:0]  o_mem_wdata,
    output logic [AW-1:0]                      o_mem_raddr,
    input  logic signed [bmhq_pkg::KEY_W-1:0]  i_mem_rdata
);

    localparam int XW = (CW > bmhq_pkg::CNT_W) ? CW : bmhq_pkg::CNT_W;
    localparam int IW = (AW > bmhq_pkg::IDX_W) ? AW : bmhq_pkg::IDX_W;
    localparam int LW = AW + 2;

    bmhq_pkg::t_state r_state, n_state;
    bmhq_pkg::t_cmd_beat r_cmd, n_cmd;
    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_p, n_p;
    logic signed [bmhq_pkg::KEY_W-1:0] r_v, n_v;
    logic signed [bmhq_pkg::KEY_W-1:0] r_top, n_top;
    logic signed [bmhq_pkg::KEY_W-1:0] r_bval, n_bval;
    logic [AW-1:0]     r_bpos, n_bpos;
    logic              r_bself, n_bself;
    logic              r_del, n_del;
    logic              r_done, n_done;
    bmhq_pkg::t_result_beat r_res, n_res;

    // Shared comparator: cmp_a < cmp_b, signed.
    logic signed [bmhq_pkg::KEY_W-1:0] cmp_a, cmp_b;
    logic              cmp_lt;

    logic              accept;
    logic              is_full;
    logic              out_range;
    logic              at_root;
    logic [AW-1:0]     parent;
    logic [LW-1:0]     lt_x, rt_x, count_l;
    logic              has_left, has_right;
    logic [CW-1:0]     count_dec;
    logic              last_gone;
    logic [IW-1:0]     idx_ext;
    logic [AW-1:0]     idx_addr;
    logic [XW-1:0]     count_x, cap_x, depth_x, index_x, n_count_x;
    logic signed [bmhq_pkg::KEY_W-1:0] fin_value;

    assign accept    = i_start && (r_state == bmhq_pkg::S_IDLE);
    assign count_x   = XW'(r_count);
    assign cap_x     = XW'(i_cap);
    assign depth_x   = XW'(DEPTH);
    assign index_x   = XW'(r_cmd.index);
    assign is_full   = (count_x >= cap_x) || (count_x >= depth_x);
    assign out_range = (index_x >= count_x);
    assign idx_ext   = IW'(r_cmd.index);
    assign idx_addr  = idx_ext[AW-1:0];
    assign at_root   = (r_p == '0);
    assign parent    = (r_p - AW'(1)) >> 1;
    assign lt_x      = {1'b0, r_p, 1'b1};
    assign rt_x      = lt_x + LW'(1);
    assign count_l   = LW'(r_count);
    assign has_left  = (lt_x < count_l);
    assign has_right = (rt_x < count_l);
    assign count_dec = r_count - CW'(1);
    assign last_gone = (count_dec == '0);
    assign fin_value = (r_cmd.cmd == bmhq_pkg::CMD_EXTRACT) ? r_top : '0;

    always_comb begin
        cmp_a = i_mem_rdata;
        cmp_b = r_v;
        case (r_state)
            bmhq_pkg::S_DEC_CMP: begin
                cmp_a = i_mem_rdata;
                cmp_b = r_cmd.key;
            end
            bmhq_pkg::S_RISE_CMP: begin
                cmp_a = r_v;
                cmp_b = i_mem_rdata;
            end
            bmhq_pkg::S_SINK_RR: begin
                cmp_a = i_mem_rdata;
                cmp_b = r_bval;
            end
            default: begin
                cmp_a = i_mem_rdata;
                cmp_b = r_v;
            end
        endcase
    end

    assign cmp_lt = (cmp_a < cmp_b);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            bmhq_pkg::S_IDLE: begin
                if (accept) n_state = bmhq_pkg::S_DISPATCH;
            end
            bmhq_pkg::S_DISPATCH: begin
                case (r_cmd.cmd)
                    bmhq_pkg::CMD_INSERT:
                        n_state = is_full ? bmhq_pkg::S_IDLE : bmhq_pkg::S_RISE_CHK;
                    bmhq_pkg::CMD_EXTRACT:
                        n_state = (r_count == '0) ? bmhq_pkg::S_IDLE : bmhq_pkg::S_TAKE_R0;
                    bmhq_pkg::CMD_DECREASE:
                        n_state = out_range ? bmhq_pkg::S_IDLE : bmhq_pkg::S_DEC_CMP;
                    default:
                        n_state = out_range ? bmhq_pkg::S_IDLE : bmhq_pkg::S_RISE_CHK;
                endcase
            end
            bmhq_pkg::S_DEC_CMP: begin
                n_state = cmp_lt ? bmhq_pkg::S_IDLE : bmhq_pkg::S_RISE_CHK;
            end
            bmhq_pkg::S_RISE_CHK: begin
                if (!at_root) n_state = bmhq_pkg::S_RISE_CMP;
                else          n_state = r_del ? bmhq_pkg::S_TAKE_R0 : bmhq_pkg::S_IDLE;
            end
            bmhq_pkg::S_RISE_CMP: begin
                if (cmp_lt) n_state = bmhq_pkg::S_RISE_CHK;
                else        n_state = r_del ? bmhq_pkg::S_TAKE_R0 : bmhq_pkg::S_IDLE;
            end
            bmhq_pkg::S_TAKE_R0: n_state = bmhq_pkg::S_TAKE_RL;
            bmhq_pkg::S_TAKE_RL: begin
                n_state = last_gone ? bmhq_pkg::S_IDLE : bmhq_pkg::S_TAKE_LD;
            end
            bmhq_pkg::S_TAKE_LD: n_state = bmhq_pkg::S_SINK_CHK;
            bmhq_pkg::S_SINK_CHK: begin
                n_state = has_left ? bmhq_pkg::S_SINK_RL : bmhq_pkg::S_IDLE;
            end
            bmhq_pkg::S_SINK_RL: begin
                if (has_right)    n_state = bmhq_pkg::S_SINK_RR;
                else if (cmp_lt)  n_state = bmhq_pkg::S_SINK_CHK;
                else              n_state = bmhq_pkg::S_IDLE;
            end
            bmhq_pkg::S_SINK_RR: begin
                if (cmp_lt || !r_bself) n_state = bmhq_pkg::S_SINK_CHK;
                else                    n_state = bmhq_pkg::S_IDLE;
            end
            default: n_state = bmhq_pkg::S_IDLE;
        endcase
    end

    // Datapath and memory controls.
    always_comb begin
        n_cmd        = r_cmd;
        n_count      = r_count;
        n_p          = r_p;
        n_v          = r_v;
        n_top        = r_top;
        n_bval       = r_bval;
        n_bpos       = r_bpos;
        n_bself      = r_bself;
        n_del        = r_del;
        n_done       = 1'b0;
        n_res        = r_res;
        o_mem_we     = 1'b0;
        o_mem_waddr  = r_p;
        o_mem_wdata  = r_v;
        o_mem_raddr  = '0;
        case (r_state)
            bmhq_pkg::S_IDLE: begin
                if (accept) begin
                    n_cmd = i_cmd;
                    n_del = 1'b0;
                    n_top = '0;
                end
            end
            bmhq_pkg::S_DISPATCH: begin
                n_res.value  = '0;
                n_res.status = bmhq_pkg::ST_OK;
                case (r_cmd.cmd)
                    bmhq_pkg::CMD_INSERT: begin
                        if (is_full) begin
                            n_done       = 1'b1;
                            n_res.status = bmhq_pkg::ST_FULL;
                        end else begin
                            n_v     = r_cmd.key;
                            n_p     = r_count[AW-1:0];
                            n_count = r_count + CW'(1);
                        end
                    end
                    bmhq_pkg::CMD_EXTRACT: begin
                        if (r_count == '0) begin
                            n_done       = 1'b1;
                            n_res.value  = bmhq_pkg::KEY_MAX;
                            n_res.status = bmhq_pkg::ST_EMPTY;
                        end
                    end
                    bmhq_pkg::CMD_DECREASE: begin
                        if (out_range) begin
                            n_done       = 1'b1;
                            n_res.status = bmhq_pkg::ST_RANGE;
                        end else begin
                            o_mem_raddr = idx_addr;
                        end
                    end
                    default: begin
                        if (out_range) begin
                            n_done       = 1'b1;
                            n_res.status = bmhq_pkg::ST_RANGE;
                        end else begin
                            n_v   = bmhq_pkg::KEY_MIN;
                            n_p   = idx_addr;
                            n_del = 1'b1;
                        end
                    end
                endcase
            end
            bmhq_pkg::S_DEC_CMP: begin
                // A new key above the stored one is refused.
                if (cmp_lt) begin
                    n_done       = 1'b1;
                    n_res.status = bmhq_pkg::ST_NOTSMALLER;
                end else begin
                    n_v = r_cmd.key;
                    n_p = idx_addr;
                end
            end
            bmhq_pkg::S_RISE_CHK: begin
                if (!at_root) begin
                    o_mem_raddr = parent;
                end else begin
                    o_mem_we = 1'b1;
                    n_done   = !r_del;
                end
            end
            bmhq_pkg::S_RISE_CMP: begin
                o_mem_we = 1'b1;
                if (cmp_lt) begin
                    o_mem_wdata = i_mem_rdata;
                    n_p         = parent;
                end else begin
                    n_done = !r_del;
                end
            end
            bmhq_pkg::S_TAKE_R0: begin
                o_mem_raddr = '0;
            end
            bmhq_pkg::S_TAKE_RL: begin
                n_top       = i_mem_rdata;
                n_count     = count_dec;
                o_mem_raddr = count_dec[AW-1:0];
                if (last_gone) begin
                    n_done      = 1'b1;
                    n_res.value = (r_cmd.cmd == bmhq_pkg::CMD_EXTRACT) ? i_mem_rdata : '0;
                end
            end
            bmhq_pkg::S_TAKE_LD: begin
                n_v = i_mem_rdata;
                n_p = '0;
            end
            bmhq_pkg::S_SINK_CHK: begin
                if (has_left) begin
                    o_mem_raddr = lt_x[AW-1:0];
                end else begin
                    o_mem_we    = 1'b1;
                    n_done      = 1'b1;
                    n_res.value = fin_value;
                end
            end
            bmhq_pkg::S_SINK_RL: begin
                n_bself = !cmp_lt;
                n_bval  = cmp_lt ? i_mem_rdata : r_v;
                n_bpos  = lt_x[AW-1:0];
                if (has_right) begin
                    o_mem_raddr = rt_x[AW-1:0];
                end else begin
                    o_mem_we = 1'b1;
                    if (cmp_lt) begin
                        o_mem_wdata = i_mem_rdata;
                        n_p         = lt_x[AW-1:0];
                    end else begin
                        n_done      = 1'b1;
                        n_res.value = fin_value;
                    end
                end
            end
            bmhq_pkg::S_SINK_RR: begin
                o_mem_we = 1'b1;
                if (cmp_lt) begin
                    o_mem_wdata = i_mem_rdata;
                    n_p         = rt_x[AW-1:0];
                end else if (!r_bself) begin
                    o_mem_wdata = r_bval;
                    n_p         = r_bpos;
                end else begin
                    n_done      = 1'b1;
                    n_res.value = fin_value;
                end
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    assign n_count_x   = XW'(n_count);
    always_comb begin
        o_result       = r_res;
        o_result.count = r_res.count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bmhq_pkg::S_IDLE;
            r_count <= '0;
            r_del   <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_del   <= n_del;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_p     <= n_p;
        r_v     <= n_v;
        r_top   <= n_top;
        r_bval  <= n_bval;
        r_bpos  <= n_bpos;
        r_bself <= n_bself;
        r_res   <= '{value: n_res.value, status: n_res.status,
                     count: n_count_x[bmhq_pkg::CNT_W-1:0]};
    end

    assign o_busy = (r_state != bmhq_pkg::S_IDLE);
    assign o_done = r_done;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above heap depth");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_busy)
        else $error("accepted command did not start the sequencer");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == bmhq_pkg::S_IDLE))
        else $error("result strobe while sequencer still working");

    a_rise_climbs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bmhq_pkg::S_RISE_CMP && cmp_lt) |=> (r_p < $past(r_p)))
        else $error("sift-up did not move toward the root");
`endif

endmodule

>>> rtl/core/binary_min_heap_queue.sv
// Top level of the binary min-heap priority queue: capacity register,
// key memory and heap sequencer. Depends on bmhq_pkg, bmhq_mem, bmhq_ctrl.
//
// Usage: drive a command beat on i_cmd and raise start; the beat is taken at
// a rising edge where start is high and busy is low. Commands are insert,
// extract minimum, decrease key at a heap position and delete at a position.
// Every command produces exactly one result beat on o_result, shown for one
// cycle with o_done high; the receiver cannot hold it off. A new command may
// be started in the same cycle the result is shown.
// Each sift-up level passes through a check and a compare state, and each
// sift-down level through a check state and one compare state per child,
// because the single memory read port serves every compare. Busy stays high
// while a command is worked on, so a new command is taken only after the
// last one has produced its result.
// The capacity register is written with i_cfg_we/i_cfg_data and is saturated
// to DEPTH; the user must write it only while idle; the block does not
// enforce this. Reset empties the queue and sets the capacity to 1024; key
// memory is not cleared, since only held positions are ever read.
module binary_min_heap_queue #(
    parameter int DEPTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  bmhq_pkg::t_cmd_beat           i_cmd,
    output logic                          o_done,
    output bmhq_pkg::t_result_beat        o_result,
    input  logic                          i_cfg_we,
    input  logic [bmhq_pkg::CFG_W-1:0]    i_cfg_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [bmhq_pkg::CFG_W-1:0] r_cap;

    logic                              mem_we;
    logic [AW-1:0]                     mem_waddr;
    logic signed [bmhq_pkg::KEY_W-1:0] mem_wdata;
    logic [AW-1:0]                     mem_raddr;
    logic signed [bmhq_pkg::KEY_W-1:0] mem_rdata;

    // Capacity register; its effect is saturated to DEPTH in the sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= bmhq_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_data;
        end
    end

    bmhq_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    bmhq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_cmd       (i_cmd),
        .i_cap       (r_cap),
        .o_busy      (busy),
        .o_done      (o_done),
        .o_result    (o_result),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the binary min-heap queue: a driver feeds command
// and capacity beats from a queue, a monitor predicts and checks every result.
// Depends on bmhq_pkg and binary_min_heap_queue.
module tb_top;

    import bmhq_pkg::*;

    localparam int DEPTH       = 1024;
    localparam int PERIOD      = 4;
    localparam int RESET_CYC   = 12;
    localparam int SETTLE_CYC  = 64;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_ITEMS = 112;
    localparam int NUM_PHASES  = 8;

    // What the driver does with one entry of its queue: send a command beat,
    // write the capacity register once the queue is quiet, or just wait for
    // the queue to go quiet.
    typedef enum logic [1:0] {
        ITEM_CMD,
        ITEM_CFG,
        ITEM_DRAIN
    } t_item_kind;

    typedef struct {
        t_item_kind       kind;
        t_cmd_beat        beat;
        logic [CFG_W-1:0] cap;
        int               idle_pct;
    } t_stim_item;

    // Every input starts at a known value before the first clock edge.
    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             start      = 1'b0;
    logic             busy;
    t_cmd_beat        i_cmd      = '0;
    logic             o_done;
    t_result_beat     o_result;
    logic             i_cfg_we   = 1'b0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    t_stim_item   stim_q[$];
    t_result_beat expected_q[$];

    // Number of expected beats still open, as seen after the previous edge.
    // The monitor updates it with a nonblocking assignment so the driver reads
    // a stable value at the edge.
    int outstanding_q = 0;
    int err_count     = 0;
    int result_num    = 0;
    int cycle_count   = 0;

    // Predictor state: a copy of the heap, its length and the capacity.
    logic signed [KEY_W-1:0] heap_mirror [DEPTH];
    int                      heap_len   = 0;
    logic [CFG_W-1:0]        cap_mirror = CAP_RESET;

    // Stimulus-side tracking of the entry count and capacity. The count only
    // depends on the command sequence, so the generator can aim indexes at
    // positions that are actually held.
    int gen_len = 0;
    int gen_cap = DEPTH;

    binary_min_heap_queue #(
        .DEPTH(DEPTH)
    ) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_cmd     (i_cmd),
        .o_done    (o_done),
        .o_result  (o_result),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data)
    );

    always #(PERIOD / 2) i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at result %0d: %s", result_num, msg);
        err_count++;
    endtask

    // ---------------------------------------------------------------------
    // Heap predictor
    // ---------------------------------------------------------------------

    function automatic void heap_swap(int a, int b);
        logic signed [KEY_W-1:0] t;
        t = heap_mirror[a];
        heap_mirror[a] = heap_mirror[b];
        heap_mirror[b] = t;
    endfunction

    // Move an entry toward the root while its parent is strictly greater.
    function automatic void heap_rise(int p);
        int up;
        while (p != 0) begin
            up = (p - 1) / 2;
            if (!(heap_mirror[up] > heap_mirror[p])) break;
            heap_swap(p, up);
            p = up;
        end
    endfunction

    // Move an entry toward the leaves, always swapping with the smaller child.
    // The left child wins a tie between the two children.
    function automatic void heap_sink(int p);
        int lt;
        int rt;
        int best;
        while (1) begin
            lt   = 2 * p + 1;
            rt   = 2 * p + 2;
            best = p;
            if (lt < heap_len && heap_mirror[lt] < heap_mirror[best]) best = lt;
            if (rt < heap_len && heap_mirror[rt] < heap_mirror[best]) best = rt;
            if (best == p) break;
            heap_swap(p, best);
            p = best;
        end
    endfunction

    function automatic logic signed [KEY_W-1:0] heap_take_min();
        logic signed [KEY_W-1:0] top;
        top = heap_mirror[0];
        heap_len--;
        if (heap_len > 0) begin
            heap_mirror[0] = heap_mirror[heap_len];
            heap_sink(0);
        end
        return top;
    endfunction

    // Apply one accepted command beat to the heap copy and return the result
    // beat the queue must produce for it.
    function automatic t_result_beat predict_heap_result(t_cmd_beat c);
        t_result_beat            r;
        logic signed [KEY_W-1:0] k;
        int                      idx;
        int                      eff_cap;
        k       = c.key;
        idx     = int'(c.index);
        eff_cap = (int'(cap_mirror) > DEPTH) ? DEPTH : int'(cap_mirror);
        r.value  = '0;
        r.status = ST_OK;
        case (c.cmd)
            CMD_INSERT: begin
                if (heap_len >= eff_cap) begin
                    r.status = ST_FULL;
                end else begin
                    heap_mirror[heap_len] = k;
                    heap_len++;
                    heap_rise(heap_len - 1);
                end
            end
            CMD_EXTRACT: begin
                if (heap_len == 0) begin
                    r.value  = KEY_MAX;
                    r.status = ST_EMPTY;
                end else begin
                    r.value = heap_take_min();
                end
            end
            CMD_DECREASE: begin
                if (idx >= heap_len) begin
                    r.status = ST_RANGE;
                end else if (k > heap_mirror[idx]) begin
                    r.status = ST_NOTSMALLER;
                end else begin
                    heap_mirror[idx] = k;
                    heap_rise(idx);
                end
            end
            CMD_DELETE: begin
                // The entry is forced to the smallest key, floated to the
                // root and removed from there.
                if (idx >= heap_len) begin
                    r.status = ST_RANGE;
                end else begin
                    heap_mirror[idx] = KEY_MIN;
                    heap_rise(idx);
                    void'(heap_take_min());
                end
            end
        endcase
        r.count = CNT_W'(heap_len);
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------

    task automatic push_cmd(input logic [1:0] cmd, input logic signed [KEY_W-1:0] key,
                            input int idx, input int idle_pct);
        t_stim_item it;
        it.kind        = ITEM_CMD;
        it.beat.cmd    = cmd;
        it.beat.key    = key;
        it.beat.index  = IDX_W'(idx);
        it.cap         = '0;
        it.idle_pct    = idle_pct;
        stim_q.push_back(it);
        // Keep the generator's idea of the entry count in step.
        case (cmd)
            CMD_INSERT:  if (gen_len < gen_cap) gen_len++;
            CMD_EXTRACT: if (gen_len > 0) gen_len--;
            CMD_DELETE:  if ((idx % DEPTH) < gen_len) gen_len--;
            default: ;
        endcase
    endtask

    task automatic push_cfg(input int cap);
        t_stim_item it;
        it.kind     = ITEM_CFG;
        it.beat     = '0;
        it.cap      = CFG_W'(cap);
        it.idle_pct = 0;
        stim_q.push_back(it);
        gen_cap = (cap > DEPTH) ? DEPTH : cap;
    endtask

    task automatic push_drain();
        t_stim_item it;
        it.kind     = ITEM_DRAIN;
        it.beat     = '0;
        it.cap      = '0;
        it.idle_pct = 0;
        stim_q.push_back(it);
    endtask

    // Keys fall in a narrow band as often as over the full range, so that
    // duplicates and ties occur, with the two extremes and keys near them mixed in.
    function automatic logic signed [KEY_W-1:0] pick_key();
        int                      mode;
        logic signed [KEY_W-1:0] k;
        mode = $urandom_range(9);
        if (mode < 4) begin
            k = $urandom();
        end else if (mode < 8) begin
            k = KEY_W'($urandom_range(16)) - KEY_W'(8);
        end else if (mode == 8) begin
            k = $urandom_range(1) ? KEY_MIN : KEY_MAX;
        end else begin
            k = $urandom_range(1) ? KEY_MIN + KEY_W'($urandom_range(3))
                                  : KEY_MAX - KEY_W'($urandom_range(3));
        end
        return k;
    endfunction

    // Mostly a held position, sometimes the first free one or anywhere.
    function automatic int pick_index();
        int r;
        r = $urandom_range(19);
        if (gen_len > 0 && r < 16) return $urandom_range(gen_len - 1);
        if (r < 18) return (gen_len > DEPTH - 1) ? DEPTH - 1 : gen_len;
        return $urandom_range(DEPTH - 1);
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus plan, reset and end of run
    // ---------------------------------------------------------------------

    initial begin : stim_plan
        int               phase_cap  [NUM_PHASES];
        int               phase_idle [NUM_PHASES];
        int               phase_ins  [NUM_PHASES];
        int               ph;
        int               n;
        int               r;
        logic [1:0]       cmd;
        logic signed [KEY_W-1:0] key;

        // Settings per phase: capacity, sender idle percentage, insert weight.
        // The capacity of 2047 saturates to the depth; zero refuses inserts.
        phase_cap  = '{1024, 16, 2047, 1, 7, 0, 300, 33};
        phase_idle = '{0, 75, 8, 0, 75, 8, 0, 75};
        phase_ins  = '{55, 45, 60, 40, 45, 40, 50, 45};

        // Directed part, starting on an empty queue at the reset capacity.
        push_cmd(CMD_EXTRACT,  KEY_MIN, 0, 0);          // extract when empty
        push_cmd(CMD_DECREASE, KEY_MIN, 0, 0);          // decrease out of range
        push_cmd(CMD_DELETE,   KEY_MAX, 0, 0);          // delete out of range
        push_cmd(CMD_INSERT,   KEY_MAX, 0, 0);
        push_cmd(CMD_INSERT,   KEY_MIN, 0, 0);
        push_cmd(CMD_INSERT,   '0, DEPTH - 1, 0);
        push_cmd(CMD_INSERT,   -32'sd1, 0, 0);
        push_cmd(CMD_INSERT,   KEY_MIN, 0, 0);          // smallest key again
        push_cmd(CMD_INSERT,   32'sd5, 0, 0);
        push_cmd(CMD_DECREASE, KEY_MAX, 2, 0);          // new key larger
        push_cmd(CMD_DECREASE, -32'sd1, 3, 0);          // smaller key, entry stays put
        push_cmd(CMD_DECREASE, KEY_MIN, 5, 0);          // decrease to the minimum
        push_cmd(CMD_DECREASE, '0, DEPTH - 1, 0);       // index all ones
        push_cmd(CMD_DELETE,   '0, 4, 0);               // smallest key above it
        push_cmd(CMD_DELETE,   '0, gen_len - 1, 0);     // last held position
        push_cmd(CMD_DELETE,   '0, gen_len, 0);         // first free position
        // Capacity lowered below the count keeps the entries already held.
        push_cfg(1);
        push_cmd(CMD_INSERT,   32'sd7, 0, 0);
        push_cmd(CMD_EXTRACT,  '0, 0, 0);
        push_cmd(CMD_EXTRACT,  '0, 0, 0);
        push_cmd(CMD_EXTRACT,  '0, 0, 0);
        push_cmd(CMD_INSERT,   32'sd9, 0, 0);
        push_cmd(CMD_INSERT,   32'sd3, 0, 0);           // refused at capacity one
        push_cfg(0);
        push_cmd(CMD_INSERT,   32'sd1, 0, 0);           // capacity zero refuses
        push_cmd(CMD_EXTRACT,  '0, 0, 0);

        // Random phases. Halfway through each, the driver holds off until
        // every open result has come back.
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            push_cfg(phase_cap[ph]);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2) push_drain();
                r = $urandom_range(99);
                if (r < phase_ins[ph] || (gen_len == 0 && r < 85)) begin
                    cmd = CMD_INSERT;
                end else if (r < phase_ins[ph] + (100 - phase_ins[ph]) * 2 / 5) begin
                    cmd = CMD_EXTRACT;
                end else if (r < phase_ins[ph] + (100 - phase_ins[ph]) * 7 / 10) begin
                    cmd = CMD_DECREASE;
                end else begin
                    cmd = CMD_DELETE;
                end
                // Decrease keys lean toward very small values so most of them
                // are accepted and actually move entries.
                if (cmd == CMD_DECREASE && $urandom_range(1))
                    key = KEY_MIN + KEY_W'($urandom_range(1 << 20));
                else
                    key = pick_key();
                push_cmd(cmd, key, pick_index(), phase_idle[ph]);
            end
        end

        // Single reset at the start of the run.
        repeat (RESET_CYC) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the driver to run dry and every result to come back, then
        // give the queue time to show anything stray.
        @(posedge i_clk);
        while (stim_q.size() != 0 || start || outstanding_q != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);

        if (expected_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_q.size()));
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // ---------------------------------------------------------------------
    // Driver: one beat per handshake, start held high across back-to-back
    // beats, capacity writes only while the queue is quiet.
    // ---------------------------------------------------------------------

    always @(posedge i_clk) begin : driver
        logic             nx_start;
        logic             nx_we;
        t_cmd_beat        nx_beat;
        logic [CFG_W-1:0] nx_cfg;
        logic             quiet;
        t_stim_item       head;
        nx_start = start;
        nx_we    = 1'b0;
        nx_beat  = i_cmd;
        nx_cfg   = i_cfg_data;
        // Quiet means nothing in flight: no beat offered, none being worked
        // on and no result still owed.
        quiet = !start && !busy && !i_cfg_we && outstanding_q == 0;
        if (i_rst_n) begin
            if (start && !busy) nx_start = 1'b0;
            if (!nx_start && stim_q.size() != 0) begin
                head = stim_q[0];
                case (head.kind)
                    ITEM_CMD: begin
                        if ($urandom_range(99) >= head.idle_pct) begin
                            nx_start = 1'b1;
                            nx_beat  = head.beat;
                            void'(stim_q.pop_front());
                        end
                    end
                    ITEM_CFG: begin
                        if (quiet) begin
                            nx_we  = 1'b1;
                            nx_cfg = head.cap;
                            void'(stim_q.pop_front());
                        end
                    end
                    ITEM_DRAIN: begin
                        if (quiet) void'(stim_q.pop_front());
                    end
                    default: ;
                endcase
            end
        end
        start      <= nx_start;
        i_cmd      <= nx_beat;
        i_cfg_we   <= nx_we;
        i_cfg_data <= nx_cfg;
    end

    // ---------------------------------------------------------------------
    // Monitor: checks the result beat of this edge against the oldest
    // expectation, then records any capacity write or command beat taken at
    // the same edge. A result can never belong to a beat taken at its own
    // edge, so checking first keeps the order right.
    // ---------------------------------------------------------------------

    always @(posedge i_clk) begin : monitor
        t_result_beat want;
        t_result_beat got;
        if (i_rst_n) begin
            if (o_done === 1'b1) begin
                got = o_result;
                result_num++;
                if (expected_q.size() == 0) begin
                    report_mismatch("result beat with no command outstanding");
                end else begin
                    want = expected_q.pop_front();
                    if (got.value !== want.value)
                        report_mismatch($sformatf("value %0d, expected %0d",
                                                  got.value, want.value));
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  got.status, want.status));
                    if (got.count !== want.count)
                        report_mismatch($sformatf("count %0d, expected %0d",
                                                  got.count, want.count));
                end
            end
            if (i_cfg_we) cap_mirror = i_cfg_data;
            if (start && !busy) expected_q.push_back(predict_heap_result(i_cmd));
        end
        outstanding_q <= expected_q.size();
    end

    // Watchdog: a hung queue or a lost result ends the run here.
    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule

>>> filelist.f
rtl/core/bmhq_pkg.sv
rtl/core/bmhq_mem.sv
rtl/core/bmhq_ctrl.sv
rtl/core/binary_min_heap_queue.sv
tb/tb_top.sv
